// ===== rtl/mf2d_pkg.sv =====
package mf2d_pkg;

    // Sizing
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_RADIUS = 2;
    localparam int PIX_BITS   = 16;
    localparam int DATA_BITS  = 16;

    // Fixed field widths
    localparam int RAD_BITS  = 2;
    localparam int DIM_BITS  = 11;
    localparam int IDX_BITS  = 2;

    // Derived sizes
    localparam int WIN       = 2 * MAX_RADIUS + 1;
    localparam int NWIN      = WIN * WIN;
    localparam int WIN_IDX   = $clog2(WIN);
    localparam int COL_BITS  = $clog2(MAX_WIDTH);
    localparam int WID_BITS  = $clog2(MAX_WIDTH + 1);
    localparam int ROW_BITS  = DIM_BITS + 1;
    localparam int EXT_BITS  = (ROW_BITS > WID_BITS ? ROW_BITS : WID_BITS) + 1;
    localparam int N_BITS    = $clog2(((1 << DIM_BITS) + MAX_RADIUS + 1) * MAX_WIDTH);
    localparam int RANK_BITS = $clog2(NWIN + 1);

    // Register indexes
    localparam logic [IDX_BITS-1:0] REG_RADIUS = 2'd0;
    localparam logic [IDX_BITS-1:0] REG_WIDTH  = 2'd1;
    localparam logic [IDX_BITS-1:0] REG_HEIGHT = 2'd2;

    typedef logic [PIX_BITS-1:0] pix_t;
    typedef pix_t [WIN-1:0][WIN-1:0] win_t;   // [column back][row up]

    // Per-item control that travels with the data
    typedef struct packed {
        logic                emit;
        logic                med;
        logic                last;
        logic [RAD_BITS-1:0] radius;
    } mf2d_item_t;

    // Rank of the median in a (2r+1)^2 window
    function automatic logic [RANK_BITS-1:0] median_rank(input logic [RAD_BITS-1:0] r);
        logic [RANK_BITS-1:0] rr;
        rr = RANK_BITS'(r);
        return RANK_BITS'(2 * rr * (rr + RANK_BITS'(1)));
    endfunction

endpackage

// ===== rtl/mf2d_ram.sv =====
module mf2d_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, new data passed through on a same-address write
    always_ff @(posedge aclk) begin
        if (re) begin
            if (we && (waddr == raddr)) begin
                rdata_reg <= wdata;
            end else begin
                rdata_reg <= mem[raddr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/mf2d_ctrl.sv =====
module mf2d_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          adv,
    input  logic                          s_tvalid,
    input  logic                          s_tuser,
    input  logic                          cfg_valid,
    input  logic [mf2d_pkg::IDX_BITS-1:0] cfg_index,
    input  logic [mf2d_pkg::DIM_BITS-1:0] cfg_data,
    output logic                          step,
    output logic [mf2d_pkg::COL_BITS-1:0] in_col,
    output mf2d_pkg::mf2d_item_t          item
);
    import mf2d_pkg::*;

    logic [RAD_BITS-1:0] radius_reg, radius_next;
    logic [DIM_BITS-1:0] width_reg, width_next;
    logic [DIM_BITS-1:0] height_reg, height_next;
    logic [COL_BITS-1:0] in_col_reg, in_col_next;
    logic [ROW_BITS-1:0] in_row_reg, in_row_next;
    logic [COL_BITS-1:0] out_col_reg, out_col_next;
    logic [DIM_BITS-1:0] out_row_reg, out_row_next;
    logic [N_BITS-1:0]   n_reg, n_next;

    logic [WID_BITS-1:0] w_eff;
    logic [DIM_BITS-1:0] h_eff;
    logic [RAD_BITS-1:0] r_eff;
    logic [N_BITS-1:0]   lag;
    logic [EXT_BITS-1:0] w_x, h_x, r_x, ocol_x, orow_x;
    logic                cfg_hit, ignore, emit, med, last;

    // Effective settings
    always_comb begin
        if (width_reg == '0) begin
            w_eff = WID_BITS'(1);
        end else if (EXT_BITS'(width_reg) > EXT_BITS'(MAX_WIDTH)) begin
            w_eff = WID_BITS'(MAX_WIDTH);
        end else begin
            w_eff = WID_BITS'(width_reg);
        end
        h_eff = (height_reg == '0) ? DIM_BITS'(1) : height_reg;
        r_eff = (int'(radius_reg) > MAX_RADIUS) ? RAD_BITS'(MAX_RADIUS) : radius_reg;
        lag   = (r_eff[1] ? (N_BITS'(w_eff) << 1) : '0) +
                (r_eff[0] ? N_BITS'(w_eff) : '0) + N_BITS'(r_eff);
    end

    // Per-item decisions
    always_comb begin
        w_x    = EXT_BITS'(w_eff);
        h_x    = EXT_BITS'(h_eff);
        r_x    = EXT_BITS'(r_eff);
        ocol_x = EXT_BITS'(out_col_reg);
        orow_x = EXT_BITS'(out_row_reg);
        ignore = (EXT_BITS'(in_row_reg) < h_x) && s_tuser;
        step   = s_tvalid && adv && !ignore;
        emit   = n_reg >= lag;
        med    = (orow_x >= r_x) && (orow_x + r_x < h_x) &&
                 (ocol_x >= r_x) && (ocol_x + r_x < w_x);
        last   = (orow_x + EXT_BITS'(1) >= h_x) && (ocol_x + EXT_BITS'(1) >= w_x);
        cfg_hit = cfg_valid && ((cfg_index == REG_RADIUS) || (cfg_index == REG_WIDTH) ||
                                (cfg_index == REG_HEIGHT));
    end

    // Next state
    always_comb begin
        radius_next  = radius_reg;
        width_next   = width_reg;
        height_next  = height_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        n_next       = n_reg;
        if (cfg_hit) begin
            case (cfg_index)
                REG_RADIUS: radius_next = cfg_data[RAD_BITS-1:0];
                REG_WIDTH:  width_next  = cfg_data;
                REG_HEIGHT: height_next = cfg_data;
                default:    ;
            endcase
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
            n_next       = '0;
        end else if (step) begin
            if (emit && last) begin
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
                n_next       = '0;
            end else begin
                n_next = n_reg + N_BITS'(1);
                if (EXT_BITS'(in_col_reg) + EXT_BITS'(1) >= w_x) begin
                    in_col_next = '0;
                    in_row_next = in_row_reg + ROW_BITS'(1);
                end else begin
                    in_col_next = in_col_reg + COL_BITS'(1);
                end
                if (emit) begin
                    if (ocol_x + EXT_BITS'(1) >= w_x) begin
                        out_col_next = '0;
                        out_row_next = out_row_reg + DIM_BITS'(1);
                    end else begin
                        out_col_next = out_col_reg + COL_BITS'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg  <= RAD_BITS'(1);
            width_reg   <= DIM_BITS'(1024);
            height_reg  <= DIM_BITS'(1024);
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            n_reg       <= '0;
        end else begin
            radius_reg  <= radius_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            n_reg       <= n_next;
        end
    end

    assign in_col      = in_col_reg;
    assign item.emit   = emit;
    assign item.med    = med;
    assign item.last   = last;
    assign item.radius = r_eff;

endmodule

// ===== rtl/mf2d_window.sv =====
module mf2d_window (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          adv,
    input  logic                          step,
    input  logic [mf2d_pkg::PIX_BITS-1:0] pixel,
    input  logic [mf2d_pkg::COL_BITS-1:0] in_col,
    input  mf2d_pkg::mf2d_item_t          item,
    output logic                          win_valid,
    output mf2d_pkg::win_t                win,
    output mf2d_pkg::mf2d_item_t          win_item
);
    import mf2d_pkg::*;

    logic                s1_valid_reg;
    pix_t                s1_pix_reg;
    logic [COL_BITS-1:0] s1_col_reg;
    mf2d_item_t          s1_item_reg;
    pix_t [WIN-1:0]      stack;
    pix_t [WIN-2:0]      lb_rd;
    win_t                win_reg;
    logic                s2_valid_reg;
    mf2d_item_t          s2_item_reg;
    logic                lb_we;

    assign lb_we = adv && s1_valid_reg;

    // Line buffers: each one delays the column stack by one row
    for (genvar k = 0; k < WIN - 1; k++) begin : g_lb
        mf2d_ram #(.DEPTH(MAX_WIDTH), .WIDTH(PIX_BITS)) u_lb (
            .aclk  (aclk),
            .we    (lb_we),
            .waddr (s1_col_reg),
            .wdata (stack[k]),
            .re    (adv),
            .raddr (in_col),
            .rdata (lb_rd[k])
        );
    end

    // Column stack: current row at the bottom, older rows above
    always_comb begin
        stack[0] = s1_pix_reg;
        for (int k = 1; k < WIN; k++) begin
            stack[k] = lb_rd[k-1];
        end
    end

    // Input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= step;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_pix_reg  <= pixel;
            s1_col_reg  <= in_col;
            s1_item_reg <= item;
        end
    end

    // Window shift register, newest column at index 0
    always_ff @(posedge aclk) begin
        if (lb_we) begin
            win_reg[0] <= stack;
            for (int c = 1; c < WIN; c++) begin
                win_reg[c] <= win_reg[c-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (adv) begin
            s2_valid_reg <= s1_valid_reg && s1_item_reg.emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_item_reg <= s1_item_reg;
        end
    end

    assign win_valid = s2_valid_reg;
    assign win       = win_reg;
    assign win_item  = s2_item_reg;

endmodule

// ===== rtl/mf2d_median.sv =====
module mf2d_median (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           adv,
    input  logic                           win_valid,
    input  mf2d_pkg::win_t                 win,
    input  mf2d_pkg::mf2d_item_t           win_item,
    output logic                           out_valid,
    output logic [mf2d_pkg::DATA_BITS-1:0] out_data,
    output logic                           out_last
);
    import mf2d_pkg::*;

    pix_t [NWIN-1:0]      vals;
    logic [NWIN-1:0]      act;
    logic [NWIN-1:0]      cmp [NWIN];
    logic [WIN_IDX-1:0]   ridx;
    logic [RAD_BITS+1:0]  span;

    logic                 s3_valid_reg;
    pix_t [NWIN-1:0]      s3_vals_reg;
    logic [NWIN-1:0]      s3_act_reg;
    logic [NWIN-1:0]      s3_cmp_reg [NWIN];
    pix_t                 s3_center_reg;
    mf2d_item_t           s3_item_reg;

    logic [NWIN-1:0]      sel;
    logic [RANK_BITS-1:0] target;
    logic                 s4_valid_reg;
    pix_t [NWIN-1:0]      s4_vals_reg;
    logic [NWIN-1:0]      s4_sel_reg;
    pix_t                 s4_center_reg;
    mf2d_item_t           s4_item_reg;

    pix_t                 picked;
    logic                 out_valid_reg;
    logic [DATA_BITS-1:0] out_data_reg;
    logic                 out_last_reg;

    // Flatten the window and mark the elements inside the active square
    always_comb begin
        span = (RAD_BITS + 2)'(win_item.radius) << 1;
        ridx = WIN_IDX'(win_item.radius);
        for (int c = 0; c < WIN; c++) begin
            for (int k = 0; k < WIN; k++) begin
                vals[c*WIN + k] = win[c][k];
                act[c*WIN + k]  = (c <= int'(span)) && (k <= int'(span));
            end
        end
    end

    // Pairwise order with ties broken by position
    always_comb begin
        for (int i = 0; i < NWIN; i++) begin
            for (int j = 0; j < NWIN; j++) begin
                cmp[i][j] = (i != j) && act[j] &&
                            ((vals[j] < vals[i]) || ((vals[j] == vals[i]) && (j < i)));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (adv) begin
            s3_valid_reg <= win_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s3_vals_reg   <= vals;
            s3_act_reg    <= act;
            s3_cmp_reg    <= cmp;
            s3_center_reg <= win[ridx][ridx];
            s3_item_reg   <= win_item;
        end
    end

    // Rank each element; the one at the middle rank is the median
    always_comb begin
        target = median_rank(s3_item_reg.radius);
        for (int i = 0; i < NWIN; i++) begin
            sel[i] = s3_act_reg[i] &&
                     (RANK_BITS'($countones(s3_cmp_reg[i])) == target);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_valid_reg <= 1'b0;
        end else if (adv) begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s4_vals_reg   <= s3_vals_reg;
            s4_sel_reg    <= sel;
            s4_center_reg <= s3_center_reg;
            s4_item_reg   <= s3_item_reg;
        end
    end

    // One-hot pick of the median
    always_comb begin
        picked = '0;
        for (int i = 0; i < NWIN; i++) begin
            picked = picked | (s4_sel_reg[i] ? s4_vals_reg[i] : '0);
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_data_reg <= DATA_BITS'(s4_item_reg.med ? picked : s4_center_reg);
            out_last_reg <= s4_item_reg.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;

endmodule

// ===== rtl/median_filter_2d.sv =====
// Path: a result passes the input, window, compare, select and output registers after the
//   transaction that completes its window, which lags the pixel by r*W+r items (none for r = 0).
// Throughput: one item per cycle while the output is not stalled, set by the fully pipelined rank network.
// Reset: synchronous, active low; radius 1, width and height 1024, all counters and
//   pipeline valids cleared. Line buffers are not cleared and need no clearing pass.
module median_filter_2d (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [mf2d_pkg::DATA_BITS-1:0] s_tdata,   // [15:0] pixel_in
    input  logic                           s_tuser,   // [0] is_padding
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [mf2d_pkg::DATA_BITS-1:0] m_tdata,   // [15:0] pixel_out
    output logic                           m_tlast,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mf2d_pkg::IDX_BITS-1:0]  cfg_index,
    input  logic [mf2d_pkg::DIM_BITS-1:0]  cfg_data
);
    import mf2d_pkg::*;

    logic                adv;
    logic                step;
    logic [COL_BITS-1:0] in_col;
    mf2d_item_t          item;
    logic                win_valid;
    win_t                win;
    mf2d_item_t          win_item;

    // Whole pipeline moves whenever the output register can take a result
    assign adv       = !m_tvalid || m_tready;
    assign s_tready  = adv;
    assign cfg_ready = 1'b1;

    mf2d_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .s_tvalid  (s_tvalid),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (step),
        .in_col    (in_col),
        .item      (item)
    );

    mf2d_window u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .step      (step),
        .pixel     (s_tdata[PIX_BITS-1:0]),
        .in_col    (in_col),
        .item      (item),
        .win_valid (win_valid),
        .win       (win),
        .win_item  (win_item)
    );

    mf2d_median u_median (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .win_valid (win_valid),
        .win       (win),
        .win_item  (win_item),
        .out_valid (m_tvalid),
        .out_data  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

// ===== rtl/mf2d_checker.sv =====
module mf2d_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [mf2d_pkg::DATA_BITS-1:0] m_tdata,
    input logic                           m_tlast
);

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result pending after reset");

    // An empty output register never blocks the input
    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");

    // A stalled result stops the input side
    a_stall_back: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken during output stall");

endmodule

bind median_filter_2d mf2d_checker u_mf2d_checker (.*);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import mf2d_pkg::*;

    // Settings of one test phase
    typedef struct {
        logic [RAD_BITS-1:0] radius;
        logic [DIM_BITS-1:0] width;
        logic [DIM_BITS-1:0] height;
        int                  frames;
        int                  idle_mode;   // 0 none, 1 sender, 2 receiver, 3 both
    } phase_t;

    typedef struct {
        logic [PIX_BITS-1:0] pixel;
        logic                padding;
    } pix_item_t;

    typedef struct {
        logic [PIX_BITS-1:0] pixel;
        logic                last;
    } pix_result_t;

    localparam int RING_ROWS = 2 * MAX_RADIUS + 1;
    localparam int WATCHDOG  = 20000;
    // Register index past the end of the register list
    localparam logic [IDX_BITS-1:0] REG_NONE = 2'd3;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [DATA_BITS-1:0] s_tdata = '0;
    logic                 s_tuser = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [DATA_BITS-1:0] m_tdata;
    logic                 m_tlast;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [IDX_BITS-1:0]  cfg_index = '0;
    logic [DIM_BITS-1:0]  cfg_data = '0;

    median_filter_2d i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #10 aclk = ~aclk;

    // Predictor state
    logic [RAD_BITS-1:0] pr_radius = RAD_BITS'(1);
    logic [DIM_BITS-1:0] pr_width  = DIM_BITS'(1024);
    logic [DIM_BITS-1:0] pr_height = DIM_BITS'(1024);
    logic [PIX_BITS-1:0] ring [RING_ROWS*MAX_WIDTH] = '{default: '0};
    int unsigned in_col, in_row, out_col, out_row;

    pix_item_t   pending_pixels[$];
    pix_result_t filtered_queue[$];
    int          errors = 0;
    int          idle_mode = 0;
    int          hold_off = 0;
    bit          stall_req = 0;
    bit          stall_taken = 0;
    int          quiet_cycles = 0;
    bit          done = 0;

    function automatic int unsigned cur_w();
        if (pr_width == 0) return 1;
        if (pr_width > MAX_WIDTH) return MAX_WIDTH;
        return 32'(pr_width);
    endfunction

    function automatic int unsigned cur_h();
        return pr_height == 0 ? 1 : 32'(pr_height);
    endfunction

    function automatic int unsigned cur_r();
        return pr_radius > MAX_RADIUS ? MAX_RADIUS : 32'(pr_radius);
    endfunction

    function automatic logic [PIX_BITS-1:0] ring_at(int unsigned row, int unsigned col);
        return ring[(row % RING_ROWS) * MAX_WIDTH + (col % MAX_WIDTH)];
    endfunction

    // Median of the neighbourhood by insertion sort
    function automatic logic [PIX_BITS-1:0] window_median(int unsigned row, int unsigned col,
                                                         int unsigned r);
        logic [PIX_BITS-1:0] v [NWIN];
        logic [PIX_BITS-1:0] t;
        int n, j;
        n = 0;
        for (int dy = 0; dy <= 2 * r; dy++)
            for (int dx = 0; dx <= 2 * r; dx++) begin
                v[n] = ring_at(row - r + dy, col - r + dx);
                n++;
            end
        for (int i = 1; i < n; i++) begin
            t = v[i];
            j = i;
            while (j > 0 && v[j-1] > t) begin
                v[j] = v[j-1];
                j--;
            end
            v[j] = t;
        end
        return v[n/2];
    endfunction

    // Work out the result, if any, of one accepted transaction
    function automatic void predict_pixel(pix_item_t it);
        int unsigned w, h, r, n, lag;
        pix_result_t res;
        w = cur_w();
        h = cur_h();
        r = cur_r();
        if (in_row < h) begin
            if (it.padding) return;
            ring[(in_row % RING_ROWS) * MAX_WIDTH + (in_col % MAX_WIDTH)] = it.pixel;
        end
        n = in_row * w + in_col;
        in_col++;
        if (in_col >= w) begin
            in_col = 0;
            in_row++;
        end
        lag = r * w + r;
        if (n < lag) return;
        if (out_row >= r && out_row + r < h && out_col >= r && out_col + r < w)
            res.pixel = window_median(out_row, out_col, r);
        else
            res.pixel = ring_at(out_row, out_col);
        res.last = (out_row + 1 >= h) && (out_col + 1 >= w);
        filtered_queue.insert(filtered_queue.size(), res);
        if (res.last) begin
            in_col = 0; in_row = 0; out_col = 0; out_row = 0;
        end else begin
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
            end
        end
    endfunction

    // Driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                predict_pixel('{pixel: s_tdata, padding: s_tuser});
            if (!(s_tvalid && !s_tready)) begin
                if (pending_pixels.size() > 0 &&
                    !((idle_mode == 1 && $urandom_range(99) < 82) ||
                      (idle_mode == 3 && $urandom_range(99) < 10))) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_pixels[0].pixel;
                    s_tuser  <= pending_pixels[0].padding;
                    void'(pending_pixels.pop_front());
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver ready and long hold-off
    always @(posedge aclk) begin
        if (stall_req && !stall_taken) begin
            stall_taken <= 1'b1;
            hold_off    <= 300;
            m_tready    <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end else if (idle_mode >= 2) begin
            m_tready <= (idle_mode == 3) ? ($urandom_range(99) >= 10)
                                         : ($urandom_range(99) >= 82);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Monitor
    always @(posedge aclk) begin
        pix_result_t exp_res;
        if (aresetn && m_tvalid && m_tready) begin
            if (filtered_queue.size() == 0) begin
                $display("%0t: unexpected result pixel=%h last=%b", $time, m_tdata, m_tlast);
                errors++;
            end else begin
                exp_res = filtered_queue.pop_front();
                if (m_tdata !== exp_res.pixel) begin
                    $display("%0t: pixel expected %h actual %h", $time, exp_res.pixel, m_tdata);
                    errors++;
                end
                if (m_tlast !== exp_res.last) begin
                    $display("%0t: last expected %b actual %b", $time, exp_res.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    // Watchdog on accepted transactions
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
            || done || !aresetn || hold_off > 0)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic write_reg(logic [IDX_BITS-1:0] idx, logic [DIM_BITS-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_RADIUS) pr_radius = val[RAD_BITS-1:0];
        else if (idx == REG_WIDTH) pr_width = val;
        else if (idx == REG_HEIGHT) pr_height = val;
    endtask

    task automatic wait_drained();
        while (pending_pixels.size() > 0 || s_tvalid || filtered_queue.size() > 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // Queue one frame plus its flush items, with stray padding mixed in
    task automatic queue_frame(int unsigned w, int unsigned h, int unsigned r, int kind);
        pix_item_t it;
        for (int p = 0; p < w * h; p++) begin
            if ($urandom_range(19) == 0)
                pending_pixels.insert(pending_pixels.size(),
                                      '{pixel: 16'($urandom), padding: 1'b1});
            case (kind)
                0: it.pixel = 16'($urandom);
                1: it.pixel = 16'($urandom_range(3)) * 16'h5555;
                default: it.pixel = (p % 2) ? 16'hFFFF : 16'h0000;
            endcase
            it.padding = 1'b0;
            pending_pixels.insert(pending_pixels.size(), it);
        end
        for (int p = 0; p < r * w + r; p++)
            pending_pixels.insert(pending_pixels.size(),
                                  '{pixel: 16'($urandom), padding: 1'($urandom)});
    endtask

    initial begin
        phase_t phases[$];
        phase_t ph;
        int unsigned w, h, r;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset geometry is huge, so set a small frame; extremes of the fields
        phases.insert(phases.size(), '{2'd1, 11'd3, 11'd3, 1, 0});
        phases.insert(phases.size(), '{2'd0, 11'd4, 11'd2, 1, 0});
        phases.insert(phases.size(), '{2'd3, 11'd5, 11'd5, 1, 0});
        phases.insert(phases.size(), '{2'd2, 11'd0, 11'd0, 1, 0});
        phases.insert(phases.size(), '{2'd2, 11'd3, 11'd2, 1, 0});
        // Random phases across idling modes
        phases.insert(phases.size(), '{2'd1, 11'd5, 11'd4, 1, 0});
        phases.insert(phases.size(), '{2'd2, 11'd6, 11'd5, 1, 1});
        phases.insert(phases.size(), '{2'd1, 11'd5, 11'd4, 1, 2});
        phases.insert(phases.size(), '{2'd2, 11'd7, 11'd5, 1, 3});
        phases.insert(phases.size(), '{2'd3, 11'd6, 11'd6, 1, 2});
        phases.insert(phases.size(), '{2'd0, 11'd2047, 11'd1, 1, 3});

        foreach (phases[k]) begin
            ph = phases[k];
            idle_mode = ph.idle_mode;
            write_reg(REG_RADIUS, 11'(ph.radius));
            write_reg(REG_WIDTH, ph.width);
            write_reg(REG_HEIGHT, ph.height);
            write_reg(REG_NONE, 11'($urandom));
            w = cur_w(); h = cur_h(); r = cur_r();
            for (int f = 0; f < ph.frames; f++)
                queue_frame(w, h, r, (k < 5) ? (k % 3) : $urandom_range(2));
            if (k == 5) stall_req = 1'b1;
            wait_drained();
        end

        done = 1;
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/mf2d_pkg.sv
rtl/mf2d_ram.sv
rtl/mf2d_ctrl.sv
rtl/mf2d_window.sv
rtl/mf2d_median.sv
rtl/median_filter_2d.sv
rtl/mf2d_checker.sv
test/tb_top.sv
